// ===== hw/rtl/prologue_length_decoder_core_macros.svh =====
// Assertion macros shared by the prologue length decoder RTL.
`ifndef PROLOGUE_LENGTH_DECODER_CORE_MACROS_SVH
`define PROLOGUE_LENGTH_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PRLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PRLD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PRLD_ASSERT(label, prop, msg)
`define PRLD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hw/rtl/prld_pkg.sv =====
// Constants, types and opcode tables for the prologue length decoder.
package prld_pkg;

    localparam int MAX_STEAL_DEFAULT = 64;
    localparam int CFG_W             = 7;
    localparam int LEN_W             = 7;
    localparam int BYTE_W            = 8;
    localparam int INSN_W            = 5;
    localparam int SKIP_W            = 4;

    localparam logic [CFG_W-1:0] MIN_STEAL_RESET = 7'd14;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [2:0]        phase_t;
    typedef logic [SKIP_W-1:0] skip_t;

    localparam phase_t PH_PREFIX  = 3'd0;
    localparam phase_t PH_AFTER66 = 3'd1;
    localparam phase_t PH_OPCODE  = 3'd2;
    localparam phase_t PH_OPCODE2 = 3'd3;
    localparam phase_t PH_MODRM   = 3'd4;
    localparam phase_t PH_SIB     = 3'd5;
    localparam phase_t PH_SKIP    = 3'd6;

    localparam byte_t OPC_OPSIZE   = 8'h66;
    localparam byte_t OPC_ESCAPE   = 8'h0F;
    localparam logic [3:0] REX_HI  = 4'h4;

    localparam logic [2:0] OPK_BAD    = 3'd0;
    localparam logic [2:0] OPK_SIMPLE = 3'd1;
    localparam logic [2:0] OPK_MODRM  = 3'd2;
    localparam logic [2:0] OPK_MOVIMM = 3'd3;
    localparam logic [2:0] OPK_ESC    = 3'd4;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP    = 3'd5;

    typedef struct packed {
        logic [2:0] kind;
        skip_t      imm;
    } op_info_t;

    function automatic op_info_t op_lookup(input byte_t b);
        op_info_t info;
        info.kind = OPK_BAD;
        info.imm  = '0;
        unique case (b)
            8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
            8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
            8'h90, 8'hC3, 8'hCC: info.kind = OPK_SIMPLE;
            8'h01, 8'h03, 8'h09, 8'h0B, 8'h21, 8'h23, 8'h29, 8'h2B,
            8'h31, 8'h33, 8'h39, 8'h3B, 8'h84, 8'h85, 8'h87, 8'h88,
            8'h89, 8'h8A, 8'h8B, 8'h8D, 8'h63: info.kind = OPK_MODRM;
            8'h80, 8'h83, 8'hC6: begin
                info.kind = OPK_MODRM;
                info.imm  = 4'd1;
            end
            8'h81, 8'hC7: begin
                info.kind = OPK_MODRM;
                info.imm  = 4'd4;
            end
            8'hB8, 8'hB9, 8'hBA, 8'hBB,
            8'hBC, 8'hBD, 8'hBE, 8'hBF: info.kind = OPK_MOVIMM;
            OPC_ESCAPE: info.kind = OPK_ESC;
            default: info.kind = OPK_BAD;
        endcase
        return info;
    endfunction

    function automatic logic op2_listed(input byte_t b);
        logic ok;
        unique case (b)
            8'h1F, 8'hB6, 8'hB7, 8'hBE, 8'hBF,
            8'h10, 8'h11, 8'h28, 8'h29, 8'h57, 8'hEF: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== hw/rtl/prologue_length_decoder_core.sv =====
// Prologue length decoder: streaming x86-64 instruction length scan over code bytes.
//
// Channel   Direction  tdata (low bit up)         tuser
// s_        in         code_byte[7:0]             scan_start
// m_        out        steal_length[6:0], pad     scan_failed
// cfg_      in         min_steal_bytes[6:0]       -
//
// One code byte is taken every cycle while no result stalls; each beat is decoded
// from the input register, against the scan state, and any result is held in the
// output register. A stalled result stops the decode stage and, while the input
// register holds a beat, the input side as well.
// Reset clears the scan state and sets the minimum back to fourteen bytes.

`include "prologue_length_decoder_core_macros.svh"

module prologue_length_decoder_core #(
    parameter int MAX_STEAL = prld_pkg::MAX_STEAL_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [prld_pkg::CFG_W-1:0]  cfg_wr_data,   // min_steal_bytes
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,       // code_byte
    input  logic                        s_tuser,       // scan_start
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,       // steal_length, zero pad
    output logic                        m_tuser        // scan_failed
);
    import prld_pkg::*;

    localparam int TOT_RAW = $clog2(MAX_STEAL + 32);
    localparam int TOT_W   = (TOT_RAW > CFG_W) ? TOT_RAW : CFG_W;

    logic [CFG_W-1:0]  min_reg;
    logic              in_valid_reg;
    byte_t             in_byte_reg;
    logic              in_start_reg;

    logic              busy_reg, busy_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [INSN_W-1:0] insn_reg, insn_next;
    phase_t            phase_reg, phase_next;
    logic              wide_reg, wide_next;
    skip_t             imm_reg, imm_next;
    logic [1:0]        addr_reg, addr_next;
    skip_t             skip_reg, skip_next;

    logic              m_valid_reg;
    logic [LEN_W-1:0]  m_len_reg;
    logic              m_fail_reg;

    logic              out_free;
    logic              fire;
    logic              emit;
    logic              emit_fail;
    logic [LEN_W-1:0]  emit_len;

    logic              cur_busy;
    logic              fin_complete;
    logic              fin_fail;
    logic              go_after;
    skip_t             after_skip;
    skip_t             disp;
    skip_t             skip_dec;
    logic [TOT_W-1:0]  sum;
    op_info_t          info;
    logic [1:0]        mod;
    logic [2:0]        rm;

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        busy_next    = busy_reg;
        total_next   = total_reg;
        insn_next    = insn_reg + 1'b1;
        phase_next   = phase_reg;
        wide_next    = wide_reg;
        imm_next     = imm_reg;
        addr_next    = addr_reg;
        skip_next    = skip_reg;
        cur_busy     = busy_reg;
        emit         = 1'b0;
        emit_fail    = 1'b0;
        emit_len     = '0;
        fin_complete = 1'b0;
        fin_fail     = 1'b0;
        go_after     = 1'b0;
        after_skip   = '0;
        disp         = '0;
        sum          = '0;
        info         = op_lookup(in_byte_reg);
        mod          = in_byte_reg[7:6];
        rm           = in_byte_reg[2:0];
        skip_dec     = (skip_reg == '0) ? '0 : skip_reg - 1'b1;

        if (in_start_reg) begin
            cur_busy   = 1'b1;
            busy_next  = 1'b1;
            total_next = '0;
            insn_next  = INSN_W'(1);
            phase_next = PH_PREFIX;
            wide_next  = 1'b0;
            imm_next   = '0;
            addr_next  = '0;
            skip_next  = '0;
        end

        if (in_start_reg && min_reg == '0) begin
            emit = 1'b1;
        end else if (!cur_busy) begin
            insn_next = insn_reg;
        end else begin
            unique case (phase_next)
                PH_PREFIX, PH_AFTER66, PH_OPCODE: begin
                    if (phase_next == PH_PREFIX && in_byte_reg == OPC_OPSIZE) begin
                        phase_next = PH_AFTER66;
                    end else if (phase_next != PH_OPCODE && in_byte_reg[7:4] == REX_HI) begin
                        wide_next  = in_byte_reg[3];
                        phase_next = PH_OPCODE;
                    end else begin
                        unique case (info.kind)
                            OPK_SIMPLE: fin_complete = 1'b1;
                            OPK_MODRM: begin
                                imm_next   = info.imm;
                                phase_next = PH_MODRM;
                            end
                            OPK_MOVIMM: begin
                                go_after   = 1'b1;
                                after_skip = wide_next ? 4'd8 : 4'd4;
                            end
                            OPK_ESC: phase_next = PH_OPCODE2;
                            default: fin_fail = 1'b1;
                        endcase
                    end
                end
                PH_OPCODE2: begin
                    if (op2_listed(in_byte_reg)) begin
                        imm_next   = '0;
                        phase_next = PH_MODRM;
                    end else begin
                        fin_fail = 1'b1;
                    end
                end
                PH_MODRM: begin
                    if (mod == MOD_REG) begin
                        go_after   = 1'b1;
                        after_skip = imm_next;
                    end else if (mod == MOD_NODISP && rm == RM_DISP) begin
                        fin_fail = 1'b1;
                    end else if (rm == RM_SIB) begin
                        addr_next  = mod;
                        phase_next = PH_SIB;
                    end else begin
                        disp       = (mod == MOD_DISP8) ? 4'd1 :
                                     (mod == MOD_DISP32) ? 4'd4 : 4'd0;
                        go_after   = 1'b1;
                        after_skip = disp + imm_next;
                    end
                end
                PH_SIB: begin
                    if (addr_next == MOD_DISP8) begin
                        disp = 4'd1;
                    end else if (addr_next == MOD_DISP32) begin
                        disp = 4'd4;
                    end else begin
                        disp = (rm == RM_DISP) ? 4'd4 : 4'd0;
                    end
                    go_after   = 1'b1;
                    after_skip = disp + imm_next;
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        fin_complete = 1'b1;
                    end
                end
                default: fin_fail = 1'b1;
            endcase

            if (go_after) begin
                if (after_skip == '0) begin
                    fin_complete = 1'b1;
                end else begin
                    skip_next  = after_skip;
                    phase_next = PH_SKIP;
                end
            end

            if (fin_complete) begin
                sum = total_next + TOT_W'(insn_next);
                if (sum > TOT_W'(MAX_STEAL)) begin
                    fin_fail = 1'b1;
                end else if (sum >= TOT_W'(min_reg)) begin
                    emit     = 1'b1;
                    emit_len = sum[LEN_W-1:0];
                end else begin
                    total_next = sum;
                    insn_next  = '0;
                    phase_next = PH_PREFIX;
                    wide_next  = 1'b0;
                    imm_next   = '0;
                    addr_next  = '0;
                    skip_next  = '0;
                end
            end

            if (fin_fail) begin
                emit      = 1'b1;
                emit_fail = 1'b1;
                emit_len  = '0;
            end
        end

        if (emit) begin
            busy_next  = 1'b0;
            total_next = '0;
            insn_next  = '0;
            phase_next = PH_PREFIX;
            wide_next  = 1'b0;
            imm_next   = '0;
            addr_next  = '0;
            skip_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= MIN_STEAL_RESET;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            busy_reg     <= 1'b0;
            total_reg    <= '0;
            insn_reg     <= '0;
            phase_reg    <= PH_PREFIX;
            wide_reg     <= 1'b0;
            imm_reg      <= '0;
            addr_reg     <= '0;
            skip_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                min_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                m_valid_reg <= fire && emit;
            end
            if (fire) begin
                busy_reg  <= busy_next;
                total_reg <= total_next;
                insn_reg  <= insn_next;
                phase_reg <= phase_next;
                wide_reg  <= wide_next;
                imm_reg   <= imm_next;
                addr_reg  <= addr_next;
                skip_reg  <= skip_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (fire && emit) begin
            m_len_reg  <= emit_len;
            m_fail_reg <= emit_fail;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_len_reg};
    assign m_tuser  = m_fail_reg;

    `PRLD_ASSERT(a_fail_len_zero, m_valid_reg && m_fail_reg |-> m_len_reg == '0, "failure beat carries a nonzero length")
    `PRLD_ASSERT(a_ok_len_min, m_valid_reg && !m_fail_reg && m_len_reg != '0 |-> m_len_reg >= min_reg, "successful length is below the minimum")
    `PRLD_ASSERT(a_total_bound, busy_reg |-> total_reg <= TOT_W'(MAX_STEAL), "running total passed the limit")
    `PRLD_ASSERT(a_skip_live, phase_reg == PH_SKIP |-> skip_reg != '0, "skip phase with nothing left to skip")
    `PRLD_ASSERT(a_emit_idle, fire && emit |=> !busy_reg, "scan still busy after its result")
    `PRLD_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_valid_reg && !busy_reg && !in_valid_reg, "state not cleared by reset")

endmodule

// ===== verif/tb_prologue_length_decoder_core.sv =====
`timescale 1ns / 100ps
// Self-checking random testbench for the prologue length decoder core.
module tb_prologue_length_decoder_core;
    import prld_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_BEATS   = 1000;
    localparam int N_PHASES       = 8;
    localparam int MAX_GAP        = 11;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;
    localparam int QUEUE_DEPTH    = 48;
    localparam int STEAL_LIMIT    = MAX_STEAL_DEFAULT;

    localparam int N_PLAIN = 19;
    localparam logic [255:0] PLAIN_OPS = {
        8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
        8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
        8'h90, 8'hC3, 8'hCC};
    localparam int N_MODRM = 21;
    localparam logic [255:0] MODRM_OPS = {
        8'h01, 8'h03, 8'h09, 8'h0B, 8'h21, 8'h23, 8'h29, 8'h2B,
        8'h31, 8'h33, 8'h39, 8'h3B, 8'h84, 8'h85, 8'h87, 8'h88,
        8'h89, 8'h8A, 8'h8B, 8'h8D, 8'h63};
    localparam int N_IMM8 = 3;
    localparam logic [255:0] IMM8_OPS = {8'h80, 8'h83, 8'hC6};
    localparam int N_IMM32 = 2;
    localparam logic [255:0] IMM32_OPS = {8'h81, 8'hC7};
    localparam int N_MOVIMM = 8;
    localparam logic [255:0] MOVIMM_OPS = {
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF};
    localparam int N_TWO_BYTE = 11;
    localparam logic [255:0] TWO_BYTE_OPS = {
        8'h1F, 8'hB6, 8'hB7, 8'hBE, 8'hBF, 8'h10, 8'h11, 8'h28,
        8'h29, 8'h57, 8'hEF};

    typedef struct packed {
        byte_t code;
        logic  start;
    } code_beat_t;

    typedef struct packed {
        logic [LEN_W-1:0] steal_length;
        logic             scan_failed;
    } steal_result_t;

    typedef enum {F_PLAIN, F_MODRM, F_IMM8, F_IMM32, F_MOVIMM, F_TWO_BYTE} insn_form_e;
    typedef enum {FLT_OPCODE, FLT_RIP_RELATIVE, FLT_DOUBLE_PREFIX, FLT_BAD_ESCAPE} fault_e;
    typedef enum {SK_IDLE_NOISE, SK_JUNK, SK_BROKEN, SK_TRUNCATED, SK_CLEAN} scan_kind_e;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata     = '0;
    logic             s_tuser     = 1'b0;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [7:0]       m_tdata;
    logic             m_tuser;

    code_beat_t    code_beats_q[$];
    steal_result_t expected_lengths[$];
    byte_t         scan_buf[$];
    code_beat_t    next_beat;

    logic [CFG_W-1:0] min_steal = MIN_STEAL_RESET;
    logic             scan_live;
    logic [LEN_W-1:0] bytes_covered;
    logic [INSN_W-1:0] insn_count;
    phase_t           dec_phase;
    logic             rex_wide;
    logic [SKIP_W-1:0] imm_bytes;
    logic [1:0]       held_mod;
    logic [SKIP_W-1:0] operand_left;

    int queued_beats  = 0;
    int error_count   = 0;
    int idle_cycles   = 0;
    int send_wait     = 0;
    int recv_wait     = 0;
    bit send_burst    = 1'b0;
    bit recv_burst    = 1'b0;

    prologue_length_decoder_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic byte_t rand_byte();
        byte_t b;
        b = byte_t'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic byte_t pick_op(logic [255:0] list, int count);
        int idx;
        idx = $urandom_range(0, count - 1);
        return list[idx*8 +: 8];
    endfunction

    function automatic logic listed(byte_t b, logic [255:0] list, int count);
        int i;
        for (i = 0; i < count; i++) begin
            if (list[i*8 +: 8] == b) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic queue_beat(byte_t b, logic start);
        code_beat_t beat;
        beat.code  = b;
        beat.start = start;
        code_beats_q.push_back(beat);
        queued_beats++;
    endtask

    function automatic void reset_insn_state();
        insn_count   = '0;
        dec_phase    = PH_PREFIX;
        rex_wide     = 1'b0;
        imm_bytes    = '0;
        held_mod     = '0;
        operand_left = '0;
    endfunction

    function automatic void reset_scan_state();
        scan_live     = 1'b0;
        bytes_covered = '0;
        reset_insn_state();
    endfunction

    function automatic void close_scan(logic [LEN_W-1:0] len, logic failed);
        steal_result_t r;
        r.steal_length = len;
        r.scan_failed  = failed;
        expected_lengths.push_back(r);
        reset_scan_state();
    endfunction

    function automatic void account_insn();
        bytes_covered = bytes_covered + insn_count;
        if (bytes_covered > STEAL_LIMIT) begin
            close_scan('0, 1'b1);
        end else if (bytes_covered >= min_steal) begin
            close_scan(bytes_covered, 1'b0);
        end else begin
            reset_insn_state();
        end
    endfunction

    function automatic void await_operands(logic [SKIP_W-1:0] count);
        if (count == 0) begin
            account_insn();
        end else begin
            operand_left = count;
            dec_phase    = PH_SKIP;
        end
    endfunction

    function automatic void take_opcode(byte_t b);
        if (listed(b, PLAIN_OPS, N_PLAIN)) begin
            account_insn();
        end else if (listed(b, MODRM_OPS, N_MODRM)) begin
            imm_bytes = 4'd0;
            dec_phase = PH_MODRM;
        end else if (listed(b, IMM8_OPS, N_IMM8)) begin
            imm_bytes = 4'd1;
            dec_phase = PH_MODRM;
        end else if (listed(b, IMM32_OPS, N_IMM32)) begin
            imm_bytes = 4'd4;
            dec_phase = PH_MODRM;
        end else if (listed(b, MOVIMM_OPS, N_MOVIMM)) begin
            await_operands(rex_wide ? 4'd8 : 4'd4);
        end else if (b == OPC_ESCAPE) begin
            dec_phase = PH_OPCODE2;
        end else begin
            close_scan('0, 1'b1);
        end
    endfunction

    function automatic void predict_beat(byte_t b, logic start);
        logic [1:0]        mod;
        logic [2:0]        rm;
        logic [SKIP_W-1:0] disp;
        mod  = b[7:6];
        rm   = b[2:0];
        disp = '0;
        if (start) begin
            reset_scan_state();
            scan_live = 1'b1;
            if (min_steal == '0) begin
                close_scan('0, 1'b0);
            end
        end
        if (scan_live) begin
            insn_count = insn_count + 1'b1;
            case (dec_phase)
                PH_PREFIX, PH_AFTER66, PH_OPCODE: begin
                    if (dec_phase == PH_PREFIX && b == OPC_OPSIZE) begin
                        dec_phase = PH_AFTER66;
                    end else if (dec_phase != PH_OPCODE && b[7:4] == REX_HI) begin
                        rex_wide  = b[3];
                        dec_phase = PH_OPCODE;
                    end else begin
                        take_opcode(b);
                    end
                end
                PH_OPCODE2: begin
                    if (listed(b, TWO_BYTE_OPS, N_TWO_BYTE)) begin
                        imm_bytes = '0;
                        dec_phase = PH_MODRM;
                    end else begin
                        close_scan('0, 1'b1);
                    end
                end
                PH_MODRM: begin
                    if (mod == MOD_REG) begin
                        await_operands(imm_bytes);
                    end else if (mod == MOD_NODISP && rm == RM_DISP) begin
                        close_scan('0, 1'b1);
                    end else if (rm == RM_SIB) begin
                        held_mod  = mod;
                        dec_phase = PH_SIB;
                    end else begin
                        if (mod == MOD_DISP8) begin
                            disp = 4'd1;
                        end else if (mod == MOD_DISP32) begin
                            disp = 4'd4;
                        end
                        await_operands(disp + imm_bytes);
                    end
                end
                PH_SIB: begin
                    if (held_mod == MOD_DISP8) begin
                        disp = 4'd1;
                    end else if (held_mod == MOD_DISP32 || rm == RM_DISP) begin
                        disp = 4'd4;
                    end
                    await_operands(disp + imm_bytes);
                end
                PH_SKIP: begin
                    if (operand_left != 0) begin
                        operand_left = operand_left - 1'b1;
                    end
                    if (operand_left == 0) begin
                        account_insn();
                    end
                end
                default: begin
                    close_scan('0, 1'b1);
                end
            endcase
        end
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic settle_idle();
        int quiet;
        quiet = 0;
        while (quiet < SETTLE_CYCLES) begin
            @(posedge aclk);
            if (code_beats_q.size() != 0 || s_tvalid || m_tvalid ||
                expected_lengths.size() != 0) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_beat(s_tdata, s_tuser);
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (code_beats_q.size() > 0) begin
                    next_beat = code_beats_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_beat.code;
                    s_tuser  <= next_beat.start;
                    if ($urandom_range(0, 39) == 0) begin
                        send_burst = !send_burst;
                    end
                    send_wait = draw_wait(send_burst);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        steal_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_lengths.size() == 0) begin
                    flag_error($sformatf("unexpected result beat: length %0d failed %0b",
                                         m_tdata[LEN_W-1:0], m_tuser));
                end else begin
                    want = expected_lengths.pop_front();
                    if (m_tdata[LEN_W-1:0] !== want.steal_length ||
                        m_tuser !== want.scan_failed) begin
                        flag_error($sformatf(
                            "result mismatch: expected length %0d failed %0b, got %0d %0b",
                            want.steal_length, want.scan_failed,
                            m_tdata[LEN_W-1:0], m_tuser));
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    recv_burst = !recv_burst;
                end
                recv_wait = draw_wait(recv_burst);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int               goal;
        int               target;
        int               fault_at;
        int               keep;
        int               r;
        int               imm;
        int               disp;
        bit               faulted;
        bit               wide;
        bit               has_modrm;
        scan_kind_e       kind;
        insn_form_e       form;
        byte_t            rex;
        byte_t            modrm;
        byte_t            sib;
        logic [2:0]       rm;
        logic [CFG_W-1:0] setting;

        reset_scan_state();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // A stray beat while idle, a clean fourteen-byte prologue with a trailing beat,
        // then a doubled operand-size prefix, an unlisted opcode and RIP-relative addressing.
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'h55, 1'b1); queue_beat(8'h48, 1'b0); queue_beat(8'h89, 1'b0);
        queue_beat(8'hE5, 1'b0); queue_beat(8'h48, 1'b0); queue_beat(8'h83, 1'b0);
        queue_beat(8'hEC, 1'b0); queue_beat(8'h20, 1'b0); queue_beat(8'h66, 1'b0);
        queue_beat(8'h0F, 1'b0); queue_beat(8'h1F, 1'b0); queue_beat(8'h44, 1'b0);
        queue_beat(8'h00, 1'b0); queue_beat(8'h00, 1'b0); queue_beat(8'hC3, 1'b0);
        queue_beat(8'h66, 1'b1); queue_beat(8'h66, 1'b0);
        queue_beat(8'h00, 1'b1);
        queue_beat(8'h48, 1'b1); queue_beat(8'h8B, 1'b0); queue_beat(8'h05, 1'b0);

        for (int phase = 0; phase < N_PHASES; phase++) begin
            settle_idle();
            case (phase)
                0: setting = 7'd1;
                1: setting = CFG_W'(STEAL_LIMIT);
                2: setting = 7'd0;
                3: setting = 7'd127;
                4: setting = CFG_W'(STEAL_LIMIT + 1);
                5: setting = CFG_W'($urandom_range(1, STEAL_LIMIT));
                6: setting = CFG_W'($urandom_range(0, 127));
                default: setting = MIN_STEAL_RESET;
            endcase
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= setting;
            min_steal    = setting;
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;

            goal = queued_beats + RANDOM_BEATS / N_PHASES;
            while (queued_beats < goal) begin
                if (code_beats_q.size() >= QUEUE_DEPTH) begin
                    @(posedge aclk);
                end else begin
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        kind = SK_IDLE_NOISE;
                    end else if (r == 1) begin
                        kind = SK_JUNK;
                    end else if (r <= 3) begin
                        kind = SK_BROKEN;
                    end else if (r == 4) begin
                        kind = SK_TRUNCATED;
                    end else begin
                        kind = SK_CLEAN;
                    end
                    scan_buf.delete();
                    if (min_steal == 0) begin
                        target = 1;
                    end else if (min_steal > STEAL_LIMIT) begin
                        target = STEAL_LIMIT + 1;
                    end else begin
                        target = min_steal;
                    end
                    fault_at = $urandom_range(0, target - 1);
                    faulted  = 1'b0;

                    if (kind == SK_IDLE_NOISE || kind == SK_JUNK) begin
                        repeat ($urandom_range(1, kind == SK_JUNK ? 16 : 3)) begin
                            scan_buf.push_back(rand_byte());
                        end
                    end else begin
                        while (scan_buf.size() < target) begin
                            if (kind == SK_BROKEN && !faulted && scan_buf.size() >= fault_at)
                            begin
                                faulted = 1'b1;
                                case (fault_e'($urandom_range(0, 3)))
                                    FLT_OPCODE: begin
                                        scan_buf.push_back(rand_byte());
                                    end
                                    FLT_RIP_RELATIVE: begin
                                        rm = 3'($urandom_range(0, 7));
                                        scan_buf.push_back(pick_op(MODRM_OPS, N_MODRM));
                                        scan_buf.push_back({MOD_NODISP, rm, RM_DISP});
                                    end
                                    FLT_DOUBLE_PREFIX: begin
                                        scan_buf.push_back(OPC_OPSIZE);
                                        scan_buf.push_back(OPC_OPSIZE);
                                    end
                                    default: begin
                                        scan_buf.push_back(OPC_ESCAPE);
                                        scan_buf.push_back(rand_byte());
                                    end
                                endcase
                            end else begin
                                wide      = 1'b0;
                                has_modrm = 1'b1;
                                imm       = 0;
                                if ($urandom_range(0, 3) == 0) begin
                                    scan_buf.push_back(OPC_OPSIZE);
                                end
                                if ($urandom_range(0, 1) == 1) begin
                                    rex      = rand_byte();
                                    rex[7:4] = REX_HI;
                                    wide     = rex[3];
                                    scan_buf.push_back(rex);
                                end
                                form = insn_form_e'($urandom_range(0, 5));
                                case (form)
                                    F_PLAIN: begin
                                        scan_buf.push_back(pick_op(PLAIN_OPS, N_PLAIN));
                                        has_modrm = 1'b0;
                                    end
                                    F_MODRM: begin
                                        scan_buf.push_back(pick_op(MODRM_OPS, N_MODRM));
                                    end
                                    F_IMM8: begin
                                        scan_buf.push_back(pick_op(IMM8_OPS, N_IMM8));
                                        imm = 1;
                                    end
                                    F_IMM32: begin
                                        scan_buf.push_back(pick_op(IMM32_OPS, N_IMM32));
                                        imm = 4;
                                    end
                                    F_MOVIMM: begin
                                        scan_buf.push_back(pick_op(MOVIMM_OPS, N_MOVIMM));
                                        has_modrm = 1'b0;
                                        imm       = wide ? 8 : 4;
                                    end
                                    default: begin
                                        scan_buf.push_back(OPC_ESCAPE);
                                        scan_buf.push_back(pick_op(TWO_BYTE_OPS, N_TWO_BYTE));
                                    end
                                endcase
                                if (has_modrm) begin
                                    modrm = rand_byte();
                                    if (modrm[7:6] == MOD_NODISP && modrm[2:0] == RM_DISP) begin
                                        modrm[2:0] = RM_SIB;
                                    end
                                    scan_buf.push_back(modrm);
                                    disp = (modrm[7:6] == MOD_DISP8)  ? 1 :
                                           (modrm[7:6] == MOD_DISP32) ? 4 : 0;
                                    if (modrm[7:6] != MOD_REG && modrm[2:0] == RM_SIB) begin
                                        sib = rand_byte();
                                        scan_buf.push_back(sib);
                                        if (modrm[7:6] == MOD_NODISP && sib[2:0] == RM_DISP) begin
                                            disp = 4;
                                        end
                                    end
                                    repeat (disp) scan_buf.push_back(rand_byte());
                                end
                                repeat (imm) scan_buf.push_back(rand_byte());
                            end
                        end
                        if (kind == SK_TRUNCATED) begin
                            keep = $urandom_range(1, scan_buf.size());
                            while (scan_buf.size() > keep) begin
                                void'(scan_buf.pop_back());
                            end
                        end else begin
                            repeat ($urandom_range(0, 2)) scan_buf.push_back(rand_byte());
                        end
                    end

                    foreach (scan_buf[i]) begin
                        queue_beat(scan_buf[i], kind != SK_IDLE_NOISE && i == 0);
                    end
                end
            end
        end

        settle_idle();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
